/* design/puct_pkg.sv */
package puct_pkg;

    // one child of a node, as it arrives on the input channel
    typedef struct packed {
        logic [23:0]        node_visits;
        logic signed [31:0] default_value;
        logic [23:0]        child_visits;
        logic signed [31:0] child_value_sum;
        logic [15:0]        child_prior;
        logic               last_child;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         best_child;
        logic signed [31:0] best_score;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_RATIO,
        ST_LOG,
        ST_LN,
        ST_SQRT,
        ST_EF,
        ST_QSEL,
        ST_QDIV,
        ST_UMUL,
        ST_UDIV,
        ST_SCORE,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_ITER
    } t_log_phase;

    // register indexes
    localparam logic CFG_PUCT_BASE = 1'b0;
    localparam logic CFG_PUCT_INIT = 1'b1;

    localparam logic [23:0] PUCT_BASE_RST = 24'd19652;
    localparam logic [23:0] PUCT_INIT_RST = 24'd81920;

    // divider: dividend up to ((1+N+base) << 16), divisor up to 1+child_visits
    localparam int DIV_NW = 42;
    localparam int DIV_DW = 25;
    localparam int DIV_CW = $clog2(DIV_NW);

    // log2 result: 5 integer bits, 16 fraction bits
    localparam int LOG_IW = 5;
    localparam int LOG_W  = LOG_IW + 16;

    // floor(sqrt(N << 32)) fits 28 bits
    localparam int ROOT_W = 28;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

endpackage

/* design/puct_div.sv */
module puct_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [puct_pkg::DIV_NW-1:0]   i_dividend,
    input  logic [puct_pkg::DIV_DW-1:0]   i_divisor,
    output logic                          o_done,
    output logic [puct_pkg::DIV_NW-1:0]   o_quotient
);

    // restoring divider, one quotient bit per cycle, MSB first
    logic                          r_busy;
    logic                          r_done;
    logic [puct_pkg::DIV_CW-1:0]   r_cnt;
    logic [puct_pkg::DIV_DW:0]     r_rem;
    logic [puct_pkg::DIV_NW-1:0]   r_quo;
    logic [puct_pkg::DIV_DW-1:0]   r_dvs;

    logic [puct_pkg::DIV_DW:0]     rem_sh;
    logic                          ge;

    assign rem_sh = {r_rem[puct_pkg::DIV_DW-1:0], r_quo[puct_pkg::DIV_NW-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == puct_pkg::DIV_CW'(puct_pkg::DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_quo <= {r_quo[puct_pkg::DIV_NW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* design/puct_log2.sv */
module puct_log2 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [puct_pkg::DIV_NW-1:0]   i_value,
    output logic                          o_done,
    output logic [puct_pkg::LOG_W-1:0]    o_log
);

    // normalize one bit a cycle, then one fraction bit a cycle by squaring
    puct_pkg::t_log_phase           r_phase, n_phase;
    logic                           r_done;
    logic [puct_pkg::DIV_NW-1:0]    r_v;
    logic [puct_pkg::LOG_IW-1:0]    r_int;
    logic [15:0]                    r_frac;
    logic [3:0]                     r_cnt;
    logic [30:0]                    r_m;

    logic [61:0]                    sq;
    logic [31:0]                    mn;

    assign sq = 62'(r_m) * 62'(r_m);
    assign mn = sq[61:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= puct_pkg::LG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == puct_pkg::LG_ITER) && (r_cnt == 4'd15);
        end
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            puct_pkg::LG_IDLE: begin
                if (i_start) n_phase = puct_pkg::LG_NORM;
            end
            puct_pkg::LG_NORM: begin
                if (r_v[puct_pkg::DIV_NW-1]) n_phase = puct_pkg::LG_ITER;
            end
            puct_pkg::LG_ITER: begin
                if (r_cnt == 4'd15) n_phase = puct_pkg::LG_IDLE;
            end
            default: n_phase = puct_pkg::LG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            puct_pkg::LG_IDLE: begin
                if (i_start) begin
                    r_v   <= i_value;
                    r_int <= puct_pkg::LOG_IW'(puct_pkg::DIV_NW - 1 - 16);
                end
            end
            puct_pkg::LG_NORM: begin
                if (r_v[puct_pkg::DIV_NW-1]) begin
                    r_m    <= r_v[puct_pkg::DIV_NW-1 -: 31];
                    r_frac <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_v   <= {r_v[puct_pkg::DIV_NW-2:0], 1'b0};
                    r_int <= r_int - 1'b1;
                end
            end
            puct_pkg::LG_ITER: begin
                r_cnt  <= r_cnt + 1'b1;
                r_frac <= {r_frac[14:0], mn[31]};
                r_m    <= mn[31] ? mn[31:1] : mn[30:0];
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_log  = {r_int, r_frac};

endmodule

/* design/puct_sqrt.sv */
module puct_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [23:0]                   i_n,
    output logic                          o_done,
    output logic [puct_pkg::ROOT_W-1:0]   o_root
);

    // digit-by-digit root of (n << 32), two radicand bits per cycle
    logic                           r_busy;
    logic                           r_done;
    logic [4:0]                     r_cnt;
    logic [23:0]                    r_x;
    logic [30:0]                    r_rem;
    logic [puct_pkg::ROOT_W-1:0]    r_root;

    logic [30:0]                    rem_sh;
    logic [30:0]                    trial;
    logic                           ge;

    assign rem_sh = {r_rem[28:0], r_x[23:22]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'(puct_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[21:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[puct_pkg::ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* design/puct_child_select_unit.sv */
// PUCT child selector. Children of one tree node arrive one per transfer; each of the
// first MAX_CHILDREN is scored Q + U and on the transfer marked last_child the position
// and score of the best child (earliest wins ties) leave as one result transfer. One
// item is worked at a time: a later child with visits runs the shared 42-step
// bit-serial divider twice (Q and U); a child with no visits skips the Q divide. The
// first child of a node also computes the exploration factor: one more divide, a
// normalize (1 to 25 steps) and 16-step squaring log2, and a 28-step square root. A
// last child also waits for the output register to free up. A finished result waits
// in the output register while the next child is taken in.
module puct_child_select_unit #(
    parameter int MAX_CHILDREN = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  puct_pkg::t_in_item    i_item,
    output logic                  o_stall,
    output logic                  o_valid,
    output puct_pkg::t_out_item   o_result,
    input  logic                  i_stall,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [23:0]           i_cfg_data
);

    localparam int PW = $clog2(MAX_CHILDREN + 1);
    localparam int IW = $clog2(MAX_CHILDREN);

    puct_pkg::t_state       r_state, n_state;

    // configuration
    logic [23:0]            r_base;
    logic [23:0]            r_init;

    // item being worked
    puct_pkg::t_in_item     r_item;

    // node state
    logic [PW-1:0]          r_pos;
    logic [IW-1:0]          r_best_idx;
    logic signed [31:0]     r_best;
    logic [31:0]            r_ef;

    // factor intermediates
    logic [puct_pkg::LOG_W-1:0]  r_log;
    logic [24:0]                 r_pb;
    logic [puct_pkg::ROOT_W-1:0] r_sq;

    // per-child intermediates
    logic signed [32:0]     r_q;
    logic [31:0]            r_u;

    // output register
    logic                   r_ov;
    puct_pkg::t_out_item    r_out;

    // divider shared by all divides, log2 and square-root units
    logic                          div_start;
    logic [puct_pkg::DIV_NW-1:0]   div_n;
    logic [puct_pkg::DIV_DW-1:0]   div_d;
    logic                          div_done;
    logic [puct_pkg::DIV_NW-1:0]   div_q;
    logic                          log_start, log_done;
    logic [puct_pkg::LOG_W-1:0]    log_res;
    logic                          sqrt_start, sqrt_done;
    logic [puct_pkg::ROOT_W-1:0]   sqrt_res;

    // datapath
    logic [23:0]            base_eff;
    logic [25:0]            ratio_num;
    logic [52:0]            ln_prod;
    logic [52:0]            ef_prod;
    logic [47:0]            up_prod;
    logic [31:0]            vs_mag;
    logic signed [33:0]     sum;
    logic signed [31:0]     score;
    logic                   out_free;
    logic                   pos_ok;

    assign base_eff  = (r_base == 24'd0) ? 24'd1 : r_base;
    assign ratio_num = 26'(r_item.node_visits) + 26'(base_eff) + 26'd1;
    assign ln_prod   = 53'(r_log) * 53'(puct_pkg::LN2_Q32);
    assign ef_prod   = 53'(r_pb) * 53'(r_sq);
    assign up_prod   = 48'(r_ef) * 48'(r_item.child_prior);
    // |value_sum|; the most negative value maps to 2^31 unsigned
    assign vs_mag    = r_item.child_value_sum[31] ? (32'd0 - r_item.child_value_sum)
                                                  : r_item.child_value_sum;
    assign sum       = {r_q[32], r_q} + $signed({2'b00, r_u});
    assign out_free  = !r_ov || !i_stall;
    assign pos_ok    = r_pos < PW'(MAX_CHILDREN);

    // saturate Q + U to 32 bits
    always_comb begin
        if (!sum[33] && (sum[32] || sum[31])) begin
            score = 32'sh7FFF_FFFF;
        end else if (sum[33] && !(sum[32] && sum[31])) begin
            score = 32'sh8000_0000;
        end else begin
            score = sum[31:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= puct_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        div_n      = '0;
        div_d      = '0;
        log_start  = 1'b0;
        sqrt_start = 1'b0;
        unique case (r_state)
            puct_pkg::ST_IDLE: begin
                if (i_valid) n_state = puct_pkg::ST_START;
            end
            puct_pkg::ST_START: begin
                if (r_pos == '0) begin
                    // ratio = ((1 + N + base) << 16) / base
                    div_start = 1'b1;
                    div_n     = {ratio_num, 16'd0};
                    div_d     = 25'(base_eff);
                    n_state   = puct_pkg::ST_RATIO;
                end else if (pos_ok) begin
                    n_state = puct_pkg::ST_QSEL;
                end else begin
                    n_state = puct_pkg::ST_FIN;
                end
            end
            puct_pkg::ST_RATIO: begin
                if (div_done) begin
                    log_start = 1'b1;
                    n_state   = puct_pkg::ST_LOG;
                end
            end
            puct_pkg::ST_LOG: begin
                if (log_done) n_state = puct_pkg::ST_LN;
            end
            puct_pkg::ST_LN: begin
                sqrt_start = 1'b1;
                n_state    = puct_pkg::ST_SQRT;
            end
            puct_pkg::ST_SQRT: begin
                if (sqrt_done) n_state = puct_pkg::ST_EF;
            end
            puct_pkg::ST_EF: begin
                n_state = puct_pkg::ST_QSEL;
            end
            puct_pkg::ST_QSEL: begin
                if (r_item.child_visits != 24'd0) begin
                    div_start = 1'b1;
                    div_n     = puct_pkg::DIV_NW'(vs_mag);
                    div_d     = 25'(r_item.child_visits);
                    n_state   = puct_pkg::ST_QDIV;
                end else begin
                    n_state = puct_pkg::ST_UMUL;
                end
            end
            puct_pkg::ST_QDIV: begin
                if (div_done) n_state = puct_pkg::ST_UMUL;
            end
            puct_pkg::ST_UMUL: begin
                // U = ((ef * prior) >> 16) / (1 + child_visits)
                div_start = 1'b1;
                div_n     = puct_pkg::DIV_NW'(up_prod[47:16]);
                div_d     = 25'(r_item.child_visits) + 25'd1;
                n_state   = puct_pkg::ST_UDIV;
            end
            puct_pkg::ST_UDIV: begin
                if (div_done) n_state = puct_pkg::ST_SCORE;
            end
            puct_pkg::ST_SCORE: begin
                n_state = puct_pkg::ST_FIN;
            end
            puct_pkg::ST_FIN: begin
                if (!r_item.last_child || out_free) n_state = puct_pkg::ST_IDLE;
            end
            default: n_state = puct_pkg::ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= puct_pkg::PUCT_BASE_RST;
            r_init <= puct_pkg::PUCT_INIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                puct_pkg::CFG_PUCT_BASE: r_base <= i_cfg_data;
                puct_pkg::CFG_PUCT_INIT: r_init <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // node state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_best_idx <= '0;
            r_best     <= 32'sh8000_0000;
            r_ef       <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (r_state == puct_pkg::ST_EF) begin
                // (pb * sqrt(N)) >> 16, saturated
                r_ef <= (|ef_prod[52:48]) ? 32'hFFFF_FFFF : ef_prod[47:16];
            end
            if (r_state == puct_pkg::ST_SCORE) begin
                if (r_pos == '0 || score > r_best) begin
                    r_best     <= score;
                    r_best_idx <= r_pos[IW-1:0];
                end
                r_pos <= r_pos + 1'b1;
            end
            if (r_state == puct_pkg::ST_FIN && r_item.last_child && out_free) begin
                r_ov       <= 1'b1;
                r_pos      <= '0;
                r_best_idx <= '0;
                r_best     <= 32'sh8000_0000;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == puct_pkg::ST_IDLE && i_valid) r_item <= i_item;
        if (r_state == puct_pkg::ST_LOG && log_done) r_log <= log_res;
        if (r_state == puct_pkg::ST_LN) r_pb <= 25'(ln_prod[52:32]) + 25'(r_init);
        if (r_state == puct_pkg::ST_SQRT && sqrt_done) r_sq <= sqrt_res;
        if (r_state == puct_pkg::ST_QSEL && r_item.child_visits == 24'd0) begin
            r_q <= 33'(r_item.default_value);
        end
        if (r_state == puct_pkg::ST_QDIV && div_done) begin
            r_q <= r_item.child_value_sum[31] ? (33'sd0 - $signed({1'b0, div_q[31:0]}))
                                              : $signed({1'b0, div_q[31:0]});
        end
        if (r_state == puct_pkg::ST_UDIV && div_done) r_u <= div_q[31:0];
        if (r_state == puct_pkg::ST_FIN && r_item.last_child && out_free) begin
            r_out.best_child <= 6'(r_best_idx);
            r_out.best_score <= r_best;
        end
    end

    puct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    puct_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_value (div_q),
        .o_done  (log_done),
        .o_log   (log_res)
    );

    puct_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_n     (r_item.node_visits),
        .o_done  (sqrt_done),
        .o_root  (sqrt_res)
    );

    assign o_stall  = (r_state != puct_pkg::ST_IDLE);
    assign o_valid  = r_ov;
    assign o_result = r_out;

    // a result only appears after the final child of a node
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == puct_pkg::ST_FIN && r_item.last_child))
        else $error("result without last child");

    // child counter stops at the limit
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_CHILDREN))
        else $error("child position past limit");

    // emitting a result clears the node
    a_node_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == puct_pkg::ST_FIN && r_item.last_child && out_free)
        |=> (r_pos == '0 && r_ov))
        else $error("node not cleared after result");

endmodule

/* dv/puct_child_select_checker.sv */
`timescale 1ns / 1ps

module puct_child_select_checker #(
    parameter int MAX_CHILDREN = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  puct_pkg::t_in_item   i_item,
    input  logic                 o_stall,
    input  logic                 o_valid,
    input  puct_pkg::t_out_item  o_result,
    input  logic                 i_stall,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [23:0]          i_cfg_data,
    output int                   pending_results,
    output int                   mismatch_count
);

    logic [23:0]          base_reg;
    logic [23:0]          init_reg;
    logic signed [31:0]   best_score;
    logic [5:0]           best_index;
    int unsigned          child_pos;
    logic [31:0]          explore;
    puct_pkg::t_out_item  winners_q[$];

    localparam longint unsigned LN2_Q32_L = 64'd2977044472;

    function automatic longint unsigned int_sqrt(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitv;
        v = v_in;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2 of a Q16.16 value >= 1.0, by repeated squaring in Q1.30
    function automatic longint unsigned log2_fix(input longint unsigned v);
        int p;
        longint unsigned m;
        longint unsigned res;
        p = 0;
        for (int i = 0; i < 64; i++)
            if (v[i]) p = i;
        res = longint'(p - 16) << 16;
        if (p >= 30) m = v >> (p - 30);
        else         m = v << (30 - p);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                res = res | (64'd1 << (15 - i));
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] explore_factor(input longint unsigned n);
        longint unsigned b;
        longint unsigned ratio;
        longint unsigned ln;
        longint unsigned pb;
        longint unsigned sq;
        longint unsigned e;
        b = (base_reg == 0) ? 64'd1 : 64'(base_reg);
        ratio = ((64'd1 + n + b) << 16) / b;
        ln = (log2_fix(ratio) * LN2_Q32_L) >> 32;
        pb = ln + 64'(init_reg);
        sq = int_sqrt(n << 32);
        e = (pb * sq) >> 16;
        return (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
    endfunction

    task automatic score_child(input puct_pkg::t_in_item it);
        longint              q;
        longint unsigned     u;
        longint              s;
        logic signed [31:0]  sc;
        puct_pkg::t_out_item r;
        if (child_pos == 0) explore = explore_factor(64'(it.node_visits));
        if (child_pos < MAX_CHILDREN) begin
            if (it.child_visits == 0) q = longint'(it.default_value);
            else q = longint'(it.child_value_sum) / longint'(it.child_visits);
            u = ((64'(explore) * 64'(it.child_prior)) >> 16) / (64'd1 + 64'(it.child_visits));
            s = q + longint'(u);
            if (s > 64'sd2147483647)       sc = 32'sh7FFF_FFFF;
            else if (s < -64'sd2147483648) sc = 32'sh8000_0000;
            else                           sc = s[31:0];
            // later child wins only when strictly greater
            if (child_pos == 0 || sc > best_score) begin
                best_score = sc;
                best_index = child_pos[5:0];
            end
            child_pos++;
        end
        if (it.last_child) begin
            r.best_child = best_index;
            r.best_score = best_score;
            winners_q = {winners_q, r};
            best_score = 32'sh8000_0000;
            best_index = '0;
            child_pos = 0;
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        puct_pkg::t_out_item want;
        if (!i_rst_n) begin
            base_reg = puct_pkg::PUCT_BASE_RST;
            init_reg = puct_pkg::PUCT_INIT_RST;
            best_score = 32'sh8000_0000;
            best_index = '0;
            child_pos = 0;
            explore = '0;
            mismatch_count = 0;
            winners_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == puct_pkg::CFG_PUCT_BASE) base_reg = i_cfg_data;
                else                                      init_reg = i_cfg_data;
            end
            if (o_valid && !i_stall) begin
                if (winners_q.size() == 0) begin
                    report("unexpected result", o_result.best_score, '0);
                end else begin
                    want = winners_q.pop_front();
                    if (o_result.best_child != want.best_child)
                        report("best_child", 32'(o_result.best_child), 32'(want.best_child));
                    if (o_result.best_score != want.best_score)
                        report("best_score", o_result.best_score, want.best_score);
                end
            end
            if (i_valid && !o_stall) score_child(i_item);
        end
        pending_results = winners_q.size();
    end

endmodule

/* dv/puct_child_select_unit_tb.sv */
`timescale 1ns / 1ps

module puct_child_select_unit_tb;

    localparam int MAX_KIDS    = 64;
    localparam int SETTLE_CYC  = 400;      // covers the worst-case first child
    localparam int HOLD_CYC    = 3000;     // long receiver hold-off
    localparam int LIMIT_CYC   = 3000000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    puct_pkg::t_in_item   i_item;
    logic                 o_stall;
    logic                 o_valid;
    puct_pkg::t_out_item  o_result;
    logic                 i_stall;
    logic                 i_cfg_we;
    logic                 i_cfg_idx;
    logic [23:0]          i_cfg_data;

    int pending_results;
    int mismatch_count;
    int burst_left;
    int hold_tok;       // bumped by stimulus to request a hold-off
    int cyc = 0;

    puct_child_select_unit #(.MAX_CHILDREN(MAX_KIDS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_item(i_item), .o_stall(o_stall),
        .o_valid(o_valid), .o_result(o_result), .i_stall(i_stall),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    puct_child_select_checker #(.MAX_CHILDREN(MAX_KIDS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_item(i_item), .o_stall(o_stall),
        .o_valid(o_valid), .o_result(o_result), .i_stall(i_stall),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .pending_results(pending_results), .mismatch_count(mismatch_count)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc++;
        if (cyc >= LIMIT_CYC) begin
            $display("puct_child_select_unit verification failed");
            $finish;
        end
    end

    // result side: stall pattern steps through four modes; a hold-off request holds
    // i_stall high, set by HOLD_CYC, so results back up and the input stalls
    initial begin
        int hold_left;
        int seen_tok;
        int rcv_mode;
        hold_left = 0;
        seen_tok = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_tok != seen_tok) begin
                seen_tok = hold_tok;
                hold_left = HOLD_CYC;
            end
            rcv_mode = (cyc / 256) % 4;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rcv_mode == 0) i_stall <= 1'b0;
            else if (rcv_mode == 1)     i_stall <= ($urandom_range(0, 3) == 0);
            else if (rcv_mode == 2)     i_stall <= ($urandom_range(0, 3) != 0);
            else                        i_stall <= ((cyc / 16) % 2 == 1);
        end
    end

    // one transfer; bursts of random length separated by random gaps
    task automatic send_child(input puct_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic send_fields(input logic [23:0] nv, input logic [31:0] dv,
                               input logic [23:0] cv, input logic [31:0] vs,
                               input logic [15:0] pr, input logic last);
        puct_pkg::t_in_item it;
        it.node_visits = nv;
        it.default_value = dv;
        it.child_visits = cv;
        it.child_value_sum = vs;
        it.child_prior = pr;
        it.last_child = last;
        send_child(it);
    endtask

    // sender stops until every expected result is back and the block settles
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [23:0] base_val, input logic [23:0] init_val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= puct_pkg::CFG_PUCT_BASE;
        i_cfg_data <= base_val;
        @(negedge i_clk);
        i_cfg_idx  <= puct_pkg::CFG_PUCT_INIT;
        i_cfg_data <= init_val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // random node; n_kids children, last one marked
    task automatic send_node(input int n_kids);
        logic [23:0] nv;
        logic [23:0] cv;
        logic [31:0] vs;
        for (int k = 0; k < n_kids; k++) begin
            case ($urandom_range(0, 3))
                0:       nv = 24'($urandom_range(0, 15));
                1:       nv = 24'($urandom);
                2:       nv = 24'hFF_FFFF;
                default: nv = 24'($urandom_range(1, 5000));
            endcase
            case ($urandom_range(0, 3))
                0:       cv = '0;
                1:       cv = 24'($urandom);
                default: cv = 24'($urandom_range(1, 200));
            endcase
            vs = ($urandom_range(0, 1) == 0) ? $urandom
                                             : 32'($signed($urandom_range(0, 400000)) - 200000);
            send_fields(nv, $urandom, cv, vs, 16'($urandom_range(0, 65535)), k == n_kids - 1);
        end
    endtask

    task automatic random_phase(input int n_items, input int pressure);
        int sent;
        int n;
        sent = 0;
        while (sent < n_items) begin
            if (pressure == 1 && sent >= n_items / 2) begin
                hold_tok++;
                pressure = 0;
            end
            if (pressure == 2 && sent >= n_items / 2) begin
                drain();
                pressure = 0;
            end
            if ($urandom_range(0, 39) == 0) n = $urandom_range(MAX_KIDS - 2, MAX_KIDS + 6);
            else if ($urandom_range(0, 2) == 0) n = 1;
            else n = $urandom_range(2, 8);
            send_node(n);
            sent += n;
        end
        drain();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = puct_pkg::CFG_PUCT_BASE;
        i_cfg_data = '0;
        burst_left = 0;
        hold_tok   = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset register values
        send_fields(24'd100, 32'h0001_0000, 24'd0, 32'd0, 16'hFFFF, 1'b1);   // lone child
        send_fields(24'd0, 32'h7FFF_FFFF, 24'd0, 32'd0, 16'hFFFF, 1'b0);     // zero node visits
        send_fields(24'd0, 32'h8000_0000, 24'd0, 32'd0, 16'hFFFF, 1'b1);
        // ties: identical children, the first must win
        send_fields(24'd50, 32'd0, 24'd3, 32'h0003_0000, 16'h8000, 1'b0);
        send_fields(24'd50, 32'd0, 24'd3, 32'h0003_0000, 16'h8000, 1'b0);
        send_fields(24'd50, 32'd0, 24'd3, 32'h0003_0000, 16'h8000, 1'b1);
        // saturation up; later node_visits ignored
        send_fields(24'hFF_FFFF, 32'h7FFF_FFFF, 24'd0, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
        send_fields(24'd1, 32'h8000_0000, 24'd1, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
        send_fields(24'd0, 32'h8000_0000, 24'hFF_FFFF, 32'h8000_0000, 16'h0000, 1'b1);
        // extreme child visits and value sums
        send_fields(24'hFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
        send_fields(24'h00_0001, 32'h7FFF_FFFF, 24'd1, 32'h8000_0000, 16'h0001, 1'b0);
        send_fields(24'h55_AAAA, 32'hFFFF_FFFF, 24'd7, 32'hFFFF_0001, 16'hAAAA, 1'b1);
        drain();
        // too many children, last mark past the limit
        for (int k = 0; k < MAX_KIDS + 3; k++)
            send_fields(24'd1000, 32'd0, 24'd1, 32'($signed(k) * 1000),
                        16'h1000, k == MAX_KIDS + 2);
        random_phase(150, 0);

        write_regs(24'd1, 24'hFF_FFFF);
        random_phase(170, 1);
        write_regs(24'hFF_FFFF, 24'd0);
        random_phase(170, 2);
        write_regs(24'd0, 24'($urandom));       // zero base acts as one
        random_phase(150, 0);
        write_regs(24'($urandom), 24'($urandom));
        random_phase(130, 0);

        if (mismatch_count == 0) begin
            $display("puct_child_select_unit verification clean");
        end else begin
            $display("puct_child_select_unit verification failed");
        end
        $finish;
    end

endmodule
